>>> design/rdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_pkg
// Operation codes and the result item type of the reversible deque.
// ----------------------------------------------------------------------------
package rdq_pkg;

	localparam int OpW = 3;
	localparam int ResW = 16;

	localparam logic [OpW-1:0] OP_CLEAR   = 3'd0;
	localparam logic [OpW-1:0] OP_PUSH    = 3'd1;
	localparam logic [OpW-1:0] OP_REVERSE = 3'd2;
	localparam logic [OpW-1:0] OP_DELETE  = 3'd3;
	localparam logic [OpW-1:0] OP_DRAIN   = 3'd4;

	typedef struct packed {
		logic [ResW-1:0] value_res;
		logic            last;
		logic            empty_res;
		logic            error;
		logic            overflow;
	} res_t;

endpackage
`default_nettype wire

>>> design/reversible_deque_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reversible_deque_core
// Ring-buffer deque with constant-time reverse, held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Clear, push, reverse and delete each update only the front index, the
// entry count and the flags; a push writes the RAM in the cycle it is
// accepted. A full push or a delete on an empty deque returns one result
// item, as does a drain that finds the error latched or no entries. A drain
// of N entries reads the RAM once per cycle through its single read port
// and delivers one item per cycle while the output is taken, so the block
// accepts no next item until the drain's last item is loaded. The RAM needs
// no clearing after reset, since only written slots are ever read.
module reversible_deque_core
	import rdq_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 16
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire  [OpW-1:0]   opcode,
	input  wire  [ResW-1:0]  value,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [ResW-1:0]  value_res,
	output logic             last,
	output logic             empty_res,
	output logic             error,
	output logic             overflow
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = (DATA_WIDTH < ResW) ? DATA_WIDTH : ResW;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_OUT  = 1'b1;

	logic          state_q;
	logic [PW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic          rev_q;
	logic          err_q;
	logic [CW-1:0] idx_q;

	logic [SW-1:0] mem [DEPTH];
	logic [SW-1:0] rdata_q;

	logic          out_valid_q;
	res_t          res_q;
	res_t          res_d;
	logic          load_res;

	logic          out_free;
	logic          in_acc;
	logic          full;
	logic          empty;
	logic          drain_last;
	logic          rd_en;
	logic [CW-1:0] rd_j;
	logic [CW-1:0] rd_off;
	logic [PW-1:0] rd_addr;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	logic [PW-1:0] front_dec;

	function automatic logic [PW-1:0] ring_slot(input logic [PW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return PW'(s);
	endfunction

	always_comb begin
		out_free   = !out_valid_q || out_ready;
		in_ready   = (state_q == S_IDLE) && out_free;
		in_acc     = in_valid && in_ready;
		full       = (count_q == CW'(DEPTH));
		empty      = (count_q == '0);
		drain_last = (idx_q == count_q - CW'(1));
		front_dec  = (front_q == '0) ? PW'(DEPTH - 1) : PW'(front_q - PW'(1));

		rd_j   = (state_q == S_OUT) ? CW'(idx_q + CW'(1)) : '0;
		rd_off = rev_q ? CW'(count_q - CW'(1) - rd_j) : rd_j;
		rd_addr = ring_slot(front_q, rd_off);
		rd_en  = (in_acc && opcode == OP_DRAIN && !err_q && !empty) ||
			(state_q == S_OUT && out_free && !drain_last);

		wr_en   = in_acc && opcode == OP_PUSH && !full;
		wr_addr = rev_q ? front_dec : ring_slot(front_q, count_q);

		load_res = 1'b0;
		res_d    = '0;
		if (state_q == S_OUT) begin
			if (out_free) begin
				load_res        = 1'b1;
				res_d.value_res = ResW'(rdata_q);
				res_d.last      = drain_last;
			end
		end else if (in_acc) begin
			case (opcode)
				OP_PUSH: begin
					if (full) begin
						load_res       = 1'b1;
						res_d.last     = 1'b1;
						res_d.overflow = 1'b1;
					end
				end
				OP_DELETE: begin
					if (empty) begin
						load_res    = 1'b1;
						res_d.last  = 1'b1;
						res_d.error = 1'b1;
					end
				end
				OP_DRAIN: begin
					if (err_q) begin
						load_res    = 1'b1;
						res_d.last  = 1'b1;
						res_d.error = 1'b1;
					end else if (empty) begin
						load_res        = 1'b1;
						res_d.last      = 1'b1;
						res_d.empty_res = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value[SW-1:0];
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			rev_q       <= 1'b0;
			err_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == S_OUT) begin
				if (out_free) begin
					if (drain_last) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= CW'(idx_q + CW'(1));
					end
				end
			end else if (in_acc) begin
				case (opcode)
					OP_CLEAR: begin
						front_q <= '0;
						count_q <= '0;
						rev_q   <= 1'b0;
						err_q   <= 1'b0;
					end
					OP_PUSH: begin
						if (!full) begin
							count_q <= CW'(count_q + CW'(1));
							if (rev_q) begin
								front_q <= front_dec;
							end
						end
					end
					OP_REVERSE: begin
						rev_q <= !rev_q;
					end
					OP_DELETE: begin
						if (empty) begin
							err_q <= 1'b1;
						end else begin
							count_q <= CW'(count_q - CW'(1));
							if (!rev_q) begin
								front_q <= ring_slot(front_q, CW'(1));
							end
						end
					end
					OP_DRAIN: begin
						if (!err_q && !empty) begin
							idx_q   <= '0;
							state_q <= S_OUT;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = res_q.value_res;
	assign last      = res_q.last;
	assign empty_res = res_q.empty_res;
	assign error     = res_q.error;
	assign overflow  = res_q.overflow;

endmodule
`default_nettype wire
